>>> src/fsmm_pkg.sv
// ----------------------------------------------------------------------------
// fsmm_pkg
// Shared types and constants of the small fp64 matrix multiply.
// ----------------------------------------------------------------------------
package fsmm_pkg;

	localparam int MAX_ROWS_DEF  = 16;
	localparam int MAX_COLS_DEF  = 4;
	localparam int MAX_DEPTH_DEF = 16;

	// item kinds on s_tuser
	localparam logic [1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [1:0] MODE_LOAD_C  = 2'd2;
	localparam logic [1:0] MODE_COMPUTE = 2'd3;

	// register indexes
	localparam logic [1:0] REG_ROWS  = 2'd0;
	localparam logic [1:0] REG_COLS  = 2'd1;
	localparam logic [1:0] REG_DEPTH = 2'd2;
	localparam logic [1:0] REG_ACCUM = 2'd3;

	localparam logic [4:0] ROWS_RESET  = 5'd16;
	localparam logic [2:0] COLS_RESET  = 3'd4;
	localparam logic [4:0] DEPTH_RESET = 5'd16;

	localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
	localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;

	typedef enum logic {
		FP_OP_MUL,
		FP_OP_ADD
	} fp_op_t;

	typedef struct packed {
		logic   start;
		fp_op_t op;
	} fpu_req_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_PREP,
		FS_MULT,
		FS_SUM,
		FS_RSH,
		FS_NORM,
		FS_ROUND,
		FS_DONE
	} fpu_state_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_CELL,
		SQ_MSTART,
		SQ_MWAIT,
		SQ_ASTART,
		SQ_AWAIT,
		SQ_EMIT
	} seq_state_t;

endpackage

>>> src/fsmm_ram.sv
// ----------------------------------------------------------------------------
// fsmm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fsmm_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);

	logic [63:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/fsmm_fpu.sv
// ----------------------------------------------------------------------------
// fsmm_fpu
// Multi-cycle binary64 multiply / add unit, round to nearest even.
// Multiply uses four 27x27 partial products; normalisation runs up to
// eight bits a cycle.
// ----------------------------------------------------------------------------
module fsmm_fpu import fsmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fpu_req_t    req,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] result
);

	fpu_state_t state_q, state_d;

	fp_op_t             op_q;
	logic [63:0]        a_q, b_q, res_q;
	logic [52:0]        ma_q, mb_q;
	logic [105:0]       n_q, y_q;
	logic signed [12:0] e_q;
	logic               sign_q, zsign_q, sub_q;
	logic [2:0]         step_q;
	logic [53:0]        pp_q;

	// operand decode
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, special;
	logic [63:0] special_res;
	logic [10:0] eea, eeb;

	always_comb begin
		a_nan  = (a_q[62:52] == 11'h7FF) && (a_q[51:0] != 52'd0);
		b_nan  = (b_q[62:52] == 11'h7FF) && (b_q[51:0] != 52'd0);
		a_inf  = (a_q[62:52] == 11'h7FF) && (a_q[51:0] == 52'd0);
		b_inf  = (b_q[62:52] == 11'h7FF) && (b_q[51:0] == 52'd0);
		a_zero = a_q[62:0] == 63'd0;
		b_zero = b_q[62:0] == 63'd0;
		eea    = (a_q[62:52] == 11'd0) ? 11'd1 : a_q[62:52];
		eeb    = (b_q[62:52] == 11'd0) ? 11'd1 : b_q[62:52];
		special     = 1'b1;
		special_res = 64'd0;
		if (a_nan) begin
			special_res = a_q | FP_QUIET_BIT;
		end else if (b_nan) begin
			special_res = b_q | FP_QUIET_BIT;
		end else if (op_q == FP_OP_MUL) begin
			if ((a_inf && b_zero) || (a_zero && b_inf)) begin
				special_res = FP_DEFAULT_NAN;
			end else if (a_inf || b_inf) begin
				special_res = {a_q[63] ^ b_q[63], 11'h7FF, 52'd0};
			end else begin
				special = 1'b0;
			end
		end else begin
			if (a_inf && b_inf) begin
				special_res = (a_q[63] == b_q[63]) ? a_q : FP_DEFAULT_NAN;
			end else if (a_inf) begin
				special_res = a_q;
			end else if (b_inf) begin
				special_res = b_q;
			end else begin
				special = 1'b0;
			end
		end
	end

	// add alignment: larger magnitude first, smaller shifted with sticky jam
	logic         swap, ylost;
	logic [63:0]  x_w, y_w;
	logic [10:0]  ex, ey, gap;
	logic [52:0]  mx, my;
	logic [105:0] yfull, ysh;

	always_comb begin
		swap  = b_q[62:0] > a_q[62:0];
		x_w   = swap ? b_q : a_q;
		y_w   = swap ? a_q : b_q;
		ex    = (x_w[62:52] == 11'd0) ? 11'd1 : x_w[62:52];
		ey    = (y_w[62:52] == 11'd0) ? 11'd1 : y_w[62:52];
		mx    = {x_w[62:52] != 11'd0, x_w[51:0]};
		my    = {y_w[62:52] != 11'd0, y_w[51:0]};
		gap   = ex - ey;
		yfull = {1'b0, my, 52'd0};
		if (gap >= 11'd106) begin
			ysh   = 106'd0;
			ylost = my != 53'd0;
		end else begin
			ysh   = yfull >> gap;
			ylost = (ysh << gap) != yfull;
		end
	end

	// partial products
	logic [26:0] al, ah, bl, bh, pa, pb;
	logic [53:0] pp_w;
	logic [6:0]  pp_sh;

	always_comb begin
		al = ma_q[26:0];
		ah = {1'b0, ma_q[52:27]};
		bl = mb_q[26:0];
		bh = {1'b0, mb_q[52:27]};
		unique case (step_q)
			3'd0:    begin pa = al; pb = bl; end
			3'd1:    begin pa = ah; pb = bl; end
			3'd2:    begin pa = al; pb = bh; end
			default: begin pa = ah; pb = bh; end
		endcase
		pp_w = {27'd0, pa} * {27'd0, pb};
		unique case (step_q)
			3'd1:      pp_sh = 7'd0;
			3'd2, 3'd3: pp_sh = 7'd27;
			default:   pp_sh = 7'd54;
		endcase
	end

	// right shift into the subnormal range
	logic [12:0]  amt;
	logic [105:0] rsh_n;
	logic         rsh_lost;

	always_comb begin
		amt      = 13'd1 - e_q;
		rsh_n    = n_q >> amt;
		rsh_lost = (rsh_n << amt) != n_q;
	end

	// left normalisation step
	logic [3:0]         lz, nsh;
	logic signed [12:0] lim;

	always_comb begin
		priority if (n_q[105]) lz = 4'd0;
		else if (n_q[104])     lz = 4'd1;
		else if (n_q[103])     lz = 4'd2;
		else if (n_q[102])     lz = 4'd3;
		else if (n_q[101])     lz = 4'd4;
		else if (n_q[100])     lz = 4'd5;
		else if (n_q[99])      lz = 4'd6;
		else if (n_q[98])      lz = 4'd7;
		else                   lz = 4'd8;
		lim = e_q - 13'sd1;
		nsh = (lim < $signed({9'd0, lz})) ? lim[3:0] : lz;
	end

	// rounding
	logic        g_bit, st_bit, up;
	logic [53:0] s54;
	logic [52:0] sig2;
	logic [12:0] e2;
	logic [63:0] rnd;

	always_comb begin
		g_bit  = n_q[52];
		st_bit = n_q[51:0] != 52'd0;
		up     = g_bit && (st_bit || n_q[53]);
		s54    = {1'b0, n_q[105:53]} + {53'd0, up};
		if (s54[53]) begin
			sig2 = s54[53:1];
			e2   = e_q + 13'sd1;
		end else begin
			sig2 = s54[52:0];
			e2   = e_q;
		end
		if ($signed(e2) >= 13'sd2047) begin
			rnd = {sign_q, 11'h7FF, 52'd0};
		end else begin
			rnd = {sign_q, sig2[52] ? e2[10:0] : 11'd0, sig2[51:0]};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (req.start) state_d = FS_PREP;
			end
			FS_PREP: begin
				if (special)                 state_d = FS_DONE;
				else if (op_q == FP_OP_MUL)  state_d = FS_MULT;
				else                         state_d = FS_SUM;
			end
			FS_MULT: begin
				if (step_q == 3'd4) state_d = FS_RSH;
			end
			FS_SUM: state_d = FS_RSH;
			FS_RSH: begin
				if (n_q == 106'd0 || e_q <= 13'sd0) state_d = FS_ROUND;
				else                                 state_d = FS_NORM;
			end
			FS_NORM: begin
				if (n_q[105] || e_q == 13'sd1) state_d = FS_ROUND;
			end
			FS_ROUND: state_d = FS_DONE;
			FS_DONE:  state_d = FS_IDLE;
			default:  state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			FS_IDLE: begin
				if (req.start) begin
					a_q  <= op_a;
					b_q  <= op_b;
					op_q <= req.op;
				end
			end
			FS_PREP: begin
				res_q <= special_res;
				if (op_q == FP_OP_MUL) begin
					ma_q    <= {a_q[62:52] != 11'd0, a_q[51:0]};
					mb_q    <= {b_q[62:52] != 11'd0, b_q[51:0]};
					n_q     <= 106'd0;
					step_q  <= 3'd0;
					e_q     <= $signed({2'd0, eea} + {2'd0, eeb} - 13'd1022);
					sign_q  <= a_q[63] ^ b_q[63];
					zsign_q <= a_q[63] ^ b_q[63];
				end else begin
					n_q     <= {1'b0, mx, 52'd0};
					y_q     <= ysh | {105'd0, ylost};
					sub_q   <= a_q[63] ^ b_q[63];
					e_q     <= $signed({2'd0, ex} + 13'd1);
					sign_q  <= x_w[63];
					zsign_q <= a_q[63] & b_q[63];
				end
			end
			FS_MULT: begin
				if (step_q != 3'd4) pp_q <= pp_w;
				if (step_q != 3'd0) n_q <= n_q + ({52'd0, pp_q} << pp_sh);
				step_q <= step_q + 3'd1;
			end
			FS_SUM: begin
				n_q <= sub_q ? (n_q - y_q) : (n_q + y_q);
			end
			FS_RSH: begin
				if (n_q == 106'd0) begin
					e_q    <= 13'sd1;
					sign_q <= zsign_q;
				end else if (e_q <= 13'sd0) begin
					if (amt >= 13'd107) n_q <= {105'd0, 1'b1};
					else                n_q <= rsh_n | {105'd0, rsh_lost};
					e_q <= 13'sd1;
				end
			end
			FS_NORM: begin
				if (!(n_q[105] || e_q == 13'sd1)) begin
					n_q <= n_q << nsh;
					e_q <= e_q - $signed({9'd0, nsh});
				end
			end
			FS_ROUND: res_q <= rnd;
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		done   = state_q == FS_DONE;
		result = res_q;
	end

endmodule

>>> src/fp64_small_matrix_multiply.sv
// ----------------------------------------------------------------------------
// fp64_small_matrix_multiply
// Small binary64 matrix multiply: emits A*B or C + A*B, every cell per compute item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes items. s_tuser is the kind: load A, load B, load C or
//   compute. Loads write one element, unless out of range, and produce no result;
//   one load is taken per cycle while idle. A compute item emits every cell of
//   C row-major on the m_* channel, m_tlast marking the final cell.
//   cfg_we/cfg_index/cfg_data write rows_used, cols_used, depth_used and
//   accumulate; write them only while the block is idle.
// Sequencing:
//   Each multiply-add step goes through the one shared fp64 unit, the
//   multiply first and then the add; a cell runs its k steps in turn and
//   then hands over to the output; s_tready is low for the whole compute run.
// Reset: registers return to m=16, n=4, k=16, assign mode. The element
//   stores hold no defined data until loaded.
// Stall: a waiting result sits in the output register; the next cell is
//   computed meanwhile and held until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module fp64_small_matrix_multiply import fsmm_pkg::*; #(
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int MAX_COLS  = MAX_COLS_DEF,
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // row_index[3:0], col_index[7:4], element_bits[71:8]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // out_row[3:0], out_col[5:4], cell_bits[69:6], zero pad
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
	localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
	localparam int C_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int CAW = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
	localparam int MW  = $clog2(MAX_ROWS + 1);
	localparam int NW  = $clog2(MAX_COLS + 1);
	localparam int KW  = $clog2(MAX_DEPTH + 1);
	localparam int IW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int JW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	seq_state_t state_q, state_d;

	logic [4:0]    rows_q, depth_q;
	logic [2:0]    cols_q;
	logic          accum_q, acc_mode_q;
	logic [MW-1:0] m_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q, l_q;
	logic [IW-1:0] i_q;
	logic [JW-1:0] j_q;
	logic [63:0]   acc_q, prod_q;
	logic          m_tvalid_q, olast_q;
	logic [71:0]   odata_q;

	// input item
	logic        s_accept;
	logic [1:0]  mode;
	logic [15:0] row_ext, col_ext;
	logic [63:0] element_bits;

	assign s_accept     = s_tvalid && s_tready;
	assign mode         = s_tuser;
	assign row_ext      = {12'd0, s_tdata[3:0]};
	assign col_ext      = {12'd0, s_tdata[7:4]};
	assign element_bits = s_tdata[71:8];

	// clamped dimensions
	logic [15:0] rows_ext, cols_ext, depth_ext, m_new, n_new, k_new;

	always_comb begin
		rows_ext  = {11'd0, rows_q};
		cols_ext  = {13'd0, cols_q};
		depth_ext = {11'd0, depth_q};
		if (rows_ext == 16'd0)                m_new = 16'd1;
		else if (rows_ext > 16'(MAX_ROWS))    m_new = 16'(MAX_ROWS);
		else                                  m_new = rows_ext;
		if (cols_ext == 16'd0)                n_new = 16'd1;
		else if (cols_ext > 16'(MAX_COLS))    n_new = 16'(MAX_COLS);
		else                                  n_new = cols_ext;
		if (depth_ext == 16'd0)               k_new = 16'd1;
		else if (depth_ext > 16'(MAX_DEPTH))  k_new = 16'(MAX_DEPTH);
		else                                  k_new = depth_ext;
	end

	// cell position
	logic [15:0] i_ext, j_ext, l_next, rd_l;
	logic        j_last, cell_last, more_steps, out_free;

	always_comb begin
		i_ext      = 16'(i_q);
		j_ext      = 16'(j_q);
		l_next     = 16'(l_q) + 16'd1;
		rd_l       = (state_q == SQ_CELL) ? 16'd0 : l_next;
		j_last     = j_ext == 16'(n_q) - 16'd1;
		cell_last  = j_last && (i_ext == 16'(m_q) - 16'd1);
		more_steps = l_next < 16'(k_q);
		out_free   = !m_tvalid_q || m_tready;
	end

	// stores
	logic          a_we, b_we, c_we, ab_re, c_re;
	logic [15:0]   a_wfull, b_wfull, c_wfull, a_rfull, b_rfull, c_rfull;
	logic [63:0]   a_rd, b_rd, c_rd;

	always_comb begin
		a_we    = s_accept && mode == MODE_LOAD_A &&
		          row_ext < 16'(MAX_ROWS) && col_ext < 16'(MAX_DEPTH);
		b_we    = s_accept && mode == MODE_LOAD_B &&
		          row_ext < 16'(MAX_DEPTH) && col_ext < 16'(MAX_COLS);
		c_we    = s_accept && mode == MODE_LOAD_C &&
		          row_ext < 16'(MAX_ROWS) && col_ext < 16'(MAX_COLS);
		a_wfull = row_ext * 16'(MAX_DEPTH) + col_ext;
		b_wfull = row_ext * 16'(MAX_COLS) + col_ext;
		c_wfull = row_ext * 16'(MAX_COLS) + col_ext;
		a_rfull = i_ext * 16'(MAX_DEPTH) + rd_l;
		b_rfull = rd_l * 16'(MAX_COLS) + j_ext;
		c_rfull = i_ext * 16'(MAX_COLS) + j_ext;
		ab_re   = (state_q == SQ_CELL) || (state_q == SQ_ASTART && more_steps);
		c_re    = state_q == SQ_CELL;
	end

	fsmm_ram #(.DEPTH(A_DEPTH), .AW(AAW)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_wfull[AAW-1:0]),
		.wdata (element_bits),
		.re    (ab_re),
		.raddr (a_rfull[AAW-1:0]),
		.rdata (a_rd)
	);

	fsmm_ram #(.DEPTH(B_DEPTH), .AW(BAW)) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_wfull[BAW-1:0]),
		.wdata (element_bits),
		.re    (ab_re),
		.raddr (b_rfull[BAW-1:0]),
		.rdata (b_rd)
	);

	fsmm_ram #(.DEPTH(C_DEPTH), .AW(CAW)) u_c_store (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_wfull[CAW-1:0]),
		.wdata (element_bits),
		.re    (c_re),
		.raddr (c_rfull[CAW-1:0]),
		.rdata (c_rd)
	);

	// shared fp unit
	fpu_req_t    fpu_req;
	logic [63:0] fpu_a, fpu_b, fpu_res;
	logic        fpu_done;

	fsmm_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.op_a   (fpu_a),
		.op_b   (fpu_b),
		.done   (fpu_done),
		.result (fpu_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE: begin
				if (s_accept && mode == MODE_COMPUTE) state_d = SQ_CELL;
			end
			SQ_CELL:   state_d = SQ_MSTART;
			SQ_MSTART: state_d = SQ_MWAIT;
			SQ_MWAIT: begin
				if (fpu_done) state_d = SQ_ASTART;
			end
			SQ_ASTART: state_d = SQ_AWAIT;
			SQ_AWAIT: begin
				if (fpu_done) state_d = (l_q == k_q) ? SQ_EMIT : SQ_MSTART;
			end
			SQ_EMIT: begin
				if (out_free) state_d = cell_last ? SQ_IDLE : SQ_CELL;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready    = state_q == SQ_IDLE;
		fpu_req.start = (state_q == SQ_MSTART) || (state_q == SQ_ASTART);
		fpu_req.op    = (state_q == SQ_MSTART) ? FP_OP_MUL : FP_OP_ADD;
		fpu_a       = (state_q == SQ_MSTART) ? a_rd : acc_q;
		fpu_b       = (state_q == SQ_MSTART) ? b_rd : prod_q;
		m_tvalid    = m_tvalid_q;
		m_tdata     = odata_q;
		m_tlast     = olast_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SQ_IDLE;
			rows_q     <= ROWS_RESET;
			cols_q     <= COLS_RESET;
			depth_q    <= DEPTH_RESET;
			accum_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROWS:  rows_q  <= cfg_data;
					REG_COLS:  cols_q  <= cfg_data[2:0];
					REG_DEPTH: depth_q <= cfg_data;
					REG_ACCUM: accum_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == SQ_EMIT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                  m_tvalid_q <= 1'b0;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				if (s_accept && mode == MODE_COMPUTE) begin
					m_q        <= m_new[MW-1:0];
					n_q        <= n_new[NW-1:0];
					k_q        <= k_new[KW-1:0];
					acc_mode_q <= accum_q;
					i_q        <= '0;
					j_q        <= '0;
				end
			end
			SQ_CELL: l_q <= '0;
			SQ_MSTART: begin
				if (l_q == '0) acc_q <= acc_mode_q ? c_rd : 64'd0;
			end
			SQ_MWAIT: begin
				if (fpu_done) prod_q <= fpu_res;
			end
			SQ_ASTART: l_q <= l_next[KW-1:0];
			SQ_AWAIT: begin
				if (fpu_done) acc_q <= fpu_res;
			end
			SQ_EMIT: begin
				if (out_free) begin
					odata_q <= {2'b00, acc_q, j_ext[1:0], i_ext[3:0]};
					olast_q <= cell_last;
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

>>> bench/tb_fp64_small_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_fp64_small_matrix_multiply
// Self-checking bench for the small binary64 matrix multiply.
// Loads A, B and C elements and issues computes. Expected cells are worked
// out with host double arithmetic, one rounding per multiply and per add.
// A short table of directed items runs first, then random phases of
// register settings, loads and computes. Sender bursts and receiver stalls
// are random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fp64_small_matrix_multiply import fsmm_pkg::*; ();

	typedef struct {
		logic [3:0]  row;
		logic [1:0]  col;
		logic [63:0] bits;
		logic        last;
	} cell_t;

	typedef struct {
		bit          is_cfg;
		logic [1:0]  code;
		logic [3:0]  r;
		logic [3:0]  c;
		logic [63:0] bits;
		bit          chk;
		logic [63:0] want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // row_index[3:0], col_index[7:4], element_bits[71:8]
	logic [1:0]  s_tuser;  // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // out_row[3:0], out_col[5:4], cell_bits[69:6], zero pad
	logic        m_tlast;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_data;

	logic [63:0] a_mem [256];
	logic [63:0] b_mem [64];
	logic [63:0] c_mem [64];
	bit          a_set [256];
	bit          b_set [64];
	bit          c_set [64];
	logic [4:0]  rows_reg;
	logic [2:0]  cols_reg;
	logic [4:0]  depth_reg;
	logic        acc_reg;

	cell_t       cell_q[$];
	int          err_count;
	int          items_sent;
	int          burst_left;
	int          ready_phase;
	bit          ready_stall;

	dir_row_t    dir_tab[20];

	fp64_small_matrix_multiply DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#4000000;
		$display("[fp64_small_matrix_multiply] ERROR");
		$finish;
	end

	function automatic int clamp_dim(int v, int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
		err_count++;
	endtask

	task automatic predict_cells();
		int    m, n, k;
		real   acc;
		cell_t cv;
		m = clamp_dim(int'(rows_reg), 16);
		n = clamp_dim(int'(cols_reg), 4);
		k = clamp_dim(int'(depth_reg), 16);
		for (int i = 0; i < m; i++) begin
			for (int j = 0; j < n; j++) begin
				acc = acc_reg ? $bitstoreal(c_mem[i*4+j]) : 0.0;
				for (int l = 0; l < k; l++) begin
					real prod;
					prod = $bitstoreal(a_mem[i*16+l]) * $bitstoreal(b_mem[l*4+j]);
					acc = acc + prod;
				end
				cv.row = 4'(i);
				cv.col = 2'(j);
				cv.bits = $realtobits(acc);
				cv.last = (i == m - 1) && (j == n - 1);
				cell_q.push_back(cv);
			end
		end
	endtask

	task automatic store_element(logic [1:0] mode, logic [3:0] r, logic [3:0] c,
			logic [63:0] w);
		unique case (mode)
			MODE_LOAD_A: begin
				a_mem[r*16+c] = w;
				a_set[r*16+c] = 1;
			end
			MODE_LOAD_B: begin
				if (c < 4) begin
					b_mem[r*4+c] = w;
					b_set[r*4+c] = 1;
				end
			end
			MODE_LOAD_C: begin
				if (c < 4) begin
					c_mem[r*4+c] = w;
					c_set[r*4+c] = 1;
				end
			end
			MODE_COMPUTE: predict_cells();
		endcase
	endtask

	task automatic send_item(logic [1:0] mode, logic [3:0] r, logic [3:0] c,
			logic [63:0] w);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tuser = mode;
		s_tdata = {w, c, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		store_element(mode, r, c, w);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		while (cell_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		unique case (idx)
			REG_ROWS:  rows_reg = val;
			REG_COLS:  cols_reg = val[2:0];
			REG_DEPTH: depth_reg = val;
			REG_ACCUM: acc_reg = val[0];
		endcase
	endtask

	function automatic logic [63:0] rand_fp();
		logic [63:0] sp [8];
		sp = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000};
		if ($urandom_range(0, 9) == 0)
			return sp[$urandom_range(0, 7)];
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom};
		// moderate exponents keep sums meaningful
		return {1'($urandom), 11'($urandom_range(1000, 1046)), 20'($urandom), 32'($urandom)};
	endfunction

	// receiver: free-running or stalling phases of random length
	always @(negedge clk) begin
		if (ready_phase == 0) begin
			ready_stall = $urandom_range(0, 2) == 0;
			ready_phase = $urandom_range(10, 200);
		end
		ready_phase--;
		m_tready = ready_stall ? ($urandom_range(0, 2) == 0) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cell_q.size() == 0) begin
				report("unexpected cell", m_tdata[63:0], 64'h0);
			end else begin
				cell_t want;
				want = cell_q.pop_front();
				if (m_tdata[3:0] !== want.row)
					report("out_row", 64'(m_tdata[3:0]), 64'(want.row));
				if (m_tdata[5:4] !== want.col)
					report("out_col", 64'(m_tdata[5:4]), 64'(want.col));
				if (m_tdata[69:6] !== want.bits)
					report("cell_bits", m_tdata[69:6], want.bits);
				if (m_tlast !== want.last)
					report("last_cell", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	initial begin
		int m, n, k, nload;
		logic [1:0] mode;
		logic [3:0] r, c;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_LOAD_A;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		err_count = 0;
		items_sent = 0;
		burst_left = 0;
		rows_reg = ROWS_RESET;
		cols_reg = COLS_RESET;
		depth_reg = DEPTH_RESET;
		acc_reg = 1'b0;
		foreach (a_mem[i]) begin
			a_mem[i] = '0;
			a_set[i] = 0;
		end
		foreach (b_mem[i]) begin
			b_mem[i] = '0;
			b_set[i] = 0;
			c_mem[i] = '0;
			c_set[i] = 0;
		end

		dir_tab = '{
			'{1, REG_ROWS,     0, 0, 64'd1, 0, 0},
			'{1, REG_COLS,     0, 0, 64'd1, 0, 0},
			'{1, REG_DEPTH,    0, 0, 64'd1, 0, 0},
			'{0, MODE_LOAD_A,  0, 0, 64'h4000_0000_0000_0000, 0, 0},
			'{0, MODE_LOAD_B,  0, 0, 64'h4008_0000_0000_0000, 0, 0},
			'{0, MODE_COMPUTE, 0, 0, 64'h0, 1, 64'h4018_0000_0000_0000},
			'{0, MODE_LOAD_A,  0, 0, 64'h8000_0000_0000_0000, 0, 0},
			'{0, MODE_COMPUTE, 15, 15, '1, 1, 64'h0},
			'{0, MODE_LOAD_A,  0, 0, 64'h7FEF_FFFF_FFFF_FFFF, 0, 0},
			'{0, MODE_LOAD_B,  0, 0, 64'h4000_0000_0000_0000, 0, 0},
			'{0, MODE_COMPUTE, 0, 0, 64'h0, 1, 64'h7FF0_0000_0000_0000},
			'{0, MODE_LOAD_B,  0, 0, 64'h0, 0, 0},
			'{0, MODE_COMPUTE, 0, 0, 64'h0, 1, 64'h0},
			'{0, MODE_LOAD_B,  15, 15, '1, 0, 0},
			'{0, MODE_LOAD_C,  15, 15, '1, 0, 0},
			'{0, MODE_LOAD_A,  15, 15, '1, 0, 0},
			'{0, MODE_LOAD_C,  0, 0, 64'h3FF0_0000_0000_0000, 0, 0},
			'{1, REG_ACCUM,    0, 0, 64'd1, 0, 0},
			'{0, MODE_COMPUTE, 0, 0, 64'h0, 1, 64'h3FF0_0000_0000_0000},
			'{1, REG_ACCUM,    0, 0, 64'd0, 0, 0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				write_reg(dir_tab[i].code, dir_tab[i].bits[4:0]);
			end else begin
				send_item(dir_tab[i].code, dir_tab[i].r, dir_tab[i].c, dir_tab[i].bits);
				if (dir_tab[i].chk)
					cell_q[$].bits = dir_tab[i].want;
			end
		end

		while (items_sent < 240) begin
			write_reg(REG_ROWS, $urandom_range(0, 9) == 0 ?
				5'($urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 16 : 31)) :
				5'($urandom_range(1, 4)));
			write_reg(REG_COLS, $urandom_range(0, 6) == 0 ?
				5'($urandom_range(0, 1) ? 0 : 7) : 5'($urandom_range(1, 4)));
			write_reg(REG_DEPTH, $urandom_range(0, 9) == 0 ?
				5'($urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 16 : 31)) :
				5'($urandom_range(1, 4)));
			write_reg(REG_ACCUM, 5'($urandom_range(0, 1)));
			m = clamp_dim(int'(rows_reg), 16);
			n = clamp_dim(int'(cols_reg), 4);
			k = clamp_dim(int'(depth_reg), 16);
			// huge products only with a thin shared dimension
			if (m * n * k > 128) begin
				write_reg(REG_DEPTH, 5'd1);
				k = 1;
			end
			repeat ($urandom_range(1, 2)) begin
				nload = $urandom_range(2, 12);
				repeat (nload) begin
					mode = 2'($urandom_range(0, 2));
					if ($urandom_range(0, 4) == 0) begin
						r = 4'($urandom);
						c = 4'($urandom);
					end else begin
						r = 4'($urandom_range(0, mode == MODE_LOAD_B ? k - 1 : m - 1));
						c = 4'($urandom_range(0, mode == MODE_LOAD_A ? k - 1 : n - 1));
					end
					send_item(mode, r, c, rand_fp());
				end
				for (int i = 0; i < m; i++)
					for (int l = 0; l < k; l++)
						if (!a_set[i*16+l])
							send_item(MODE_LOAD_A, 4'(i), 4'(l), rand_fp());
				for (int l = 0; l < k; l++)
					for (int j = 0; j < n; j++)
						if (!b_set[l*4+j])
							send_item(MODE_LOAD_B, 4'(l), 4'(j), rand_fp());
				if (acc_reg)
					for (int i = 0; i < m; i++)
						for (int j = 0; j < n; j++)
							if (!c_set[i*4+j])
								send_item(MODE_LOAD_C, 4'(i), 4'(j), rand_fp());
				send_item(MODE_COMPUTE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
			end
		end

		while (cell_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("[fp64_small_matrix_multiply] OK");
		else
			$display("[fp64_small_matrix_multiply] ERROR");
		$finish;
	end

endmodule
